@@ src/biquad_tone_stack_cascade_macros.svh @@
// Assertion macros shared by the checker of the tone stack cascade.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BIQUAD_TONE_STACK_CASCADE_MACROS_SVH
`define BIQUAD_TONE_STACK_CASCADE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQTSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone stack cascade check failed");

// The consequent must hold in the cycle after the antecedent.
`define BQTSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone stack cascade check failed");

`endif

@@ src/bqtsc_pkg.sv @@
// Shared constants and types of the tone stack biquad cascade.
// No dependencies; used by bqtsc_cell and biquad_tone_stack_cascade.
package bqtsc_pkg;

  localparam int DELAY_BITS    = 40;
  localparam int NUM_STAGES    = 3;
  localparam int CFG_ADDR_BITS = 3;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_BASS_FF     = 3'd0,
    REG_BASS_FB     = 3'd1,
    REG_MID_FF      = 3'd2,
    REG_MID_FB      = 3'd3,
    REG_TREBLE_FF   = 3'd4,
    REG_TREBLE_FB   = 3'd5,
    REG_GAINS       = 3'd6,
    REG_TONE_BYPASS = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_Y,
    CS_A1,
    CS_Z1,
    CS_A2,
    CS_Z2
  } cell_state_t;

endpackage

@@ src/bqtsc_cell.sv @@
// One transposed direct form II biquad cell with its own multiplier and delays.
// Depends on bqtsc_pkg; instantiated in a row by biquad_tone_stack_cascade.
module bqtsc_cell #(
  parameter int COEF_BITS = 20
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic signed [bqtsc_pkg::DELAY_BITS-1:0]    x,
  input  logic        [3*COEF_BITS-1:0]              ff,
  input  logic        [2*COEF_BITS-1:0]              fb,
  output logic                                       done,
  output logic signed [bqtsc_pkg::DELAY_BITS-1:0]    y
);

  localparam int DW = bqtsc_pkg::DELAY_BITS;
  localparam int CF = COEF_BITS - 3;
  localparam int PW = DW + COEF_BITS;
  localparam int SW = PW + 2 - CF;
  localparam logic signed [PW+1:0] HALF = {{(PW+2-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [PW:0] v,
                                                   input logic signed [DW-1:0] z);
    logic signed [PW+1:0] t;
    logic signed [SW-1:0] s;
    logic signed [SW:0]   u;
    t = {v[PW], v} + HALF;
    s = t[PW+1:CF];
    u = s + z;
    if (u > DMAX) begin
      rnd_sat = DMAX;
    end else if (u < DMIN) begin
      rnd_sat = DMIN;
    end else begin
      rnd_sat = u[DW-1:0];
    end
  endfunction

  bqtsc_pkg::cell_state_t state, state_next;

  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        acc;
  logic signed [DW-1:0]        z1;
  logic signed [DW-1:0]        z2;
  logic signed [COEF_BITS-1:0] mul_coef;
  logic signed [DW-1:0]        mul_data;
  logic                        mul_en;
  logic signed [PW:0]          rnd_in;
  logic signed [DW-1:0]        z_add;
  logic signed [DW-1:0]        sat_val;

  always_comb begin
    state_next = state;
    case (state)
      bqtsc_pkg::CS_IDLE: begin
        if (start) begin
          state_next = bqtsc_pkg::CS_Y;
        end
      end
      bqtsc_pkg::CS_Y:  state_next = bqtsc_pkg::CS_A1;
      bqtsc_pkg::CS_A1: state_next = bqtsc_pkg::CS_Z1;
      bqtsc_pkg::CS_Z1: state_next = bqtsc_pkg::CS_A2;
      bqtsc_pkg::CS_A2: state_next = bqtsc_pkg::CS_Z2;
      bqtsc_pkg::CS_Z2: state_next = bqtsc_pkg::CS_IDLE;
      default:          state_next = bqtsc_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    mul_en   = 1'b0;
    mul_coef = $signed(ff[COEF_BITS-1:0]);
    mul_data = x;
    rnd_in   = acc - prod;
    z_add    = '0;
    case (state)
      bqtsc_pkg::CS_IDLE: begin
        mul_en = start;
      end
      bqtsc_pkg::CS_Y: begin
        mul_en   = 1'b1;
        mul_coef = $signed(ff[2*COEF_BITS-1:COEF_BITS]);
        rnd_in   = prod;
        z_add    = z1;
      end
      bqtsc_pkg::CS_A1: begin
        mul_en   = 1'b1;
        mul_coef = $signed(fb[COEF_BITS-1:0]);
        mul_data = y;
      end
      bqtsc_pkg::CS_Z1: begin
        mul_en   = 1'b1;
        mul_coef = $signed(ff[3*COEF_BITS-1:2*COEF_BITS]);
        z_add    = z2;
      end
      bqtsc_pkg::CS_A2: begin
        mul_en   = 1'b1;
        mul_coef = $signed(fb[2*COEF_BITS-1:COEF_BITS]);
        mul_data = y;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign sat_val = rnd_sat(rnd_in, z_add);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqtsc_pkg::CS_IDLE;
      done  <= 1'b0;
      z1    <= '0;
      z2    <= '0;
    end else begin
      state <= state_next;
      done  <= (state == bqtsc_pkg::CS_Z2);
      if (state == bqtsc_pkg::CS_Z1) begin
        z1 <= sat_val;
      end
      if (state == bqtsc_pkg::CS_Z2) begin
        z2 <= sat_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_data * mul_coef;
    end
    if (state == bqtsc_pkg::CS_Y) begin
      y <= sat_val;
    end
    if (state inside {bqtsc_pkg::CS_A1, bqtsc_pkg::CS_A2}) begin
      acc <= prod;
    end
  end

endmodule

@@ src/bqtsc_gain.sv @@
// Gain multiplier with half-up rounding and saturation.
// Depends on nothing; used for the input and output gains of the cascade.
module bqtsc_gain #(
  parameter int IN_W      = 24,
  parameter int OUT_W     = 40,
  parameter int COEF_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [IN_W-1:0]      din,
  input  logic signed [COEF_BITS-1:0] gain,
  output logic                        done,
  output logic signed [OUT_W-1:0]     dout
);

  localparam int CF = COEF_BITS - 3;
  localparam int GP = IN_W + COEF_BITS;
  localparam int SW = GP + 1 - CF;
  localparam logic signed [GP:0]      HALF = {{(GP+1-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OMAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OMIN = {1'b1, {(OUT_W-1){1'b0}}};

  function automatic logic signed [OUT_W-1:0] rnd_sat(input logic signed [GP-1:0] p);
    logic signed [GP:0]         t;
    logic signed [SW-1:0]       s;
    logic signed [SW+OUT_W-1:0] e;
    t = {p[GP-1], p} + HALF;
    s = t[GP:CF];
    e = s;
    if (e > OMAX) begin
      rnd_sat = OMAX;
    end else if (e < OMIN) begin
      rnd_sat = OMIN;
    end else begin
      rnd_sat = e[OUT_W-1:0];
    end
  endfunction

  logic signed [GP-1:0] prod;
  logic                 prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= start;
      done       <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= din * gain;
    end
    if (prod_valid) begin
      dout <= rnd_sat(prod);
    end
  end

endmodule

@@ src/biquad_tone_stack_cascade.sv @@
// Top level of the tone stack: input gain, a row of three biquad cells, output gain.
// Depends on bqtsc_pkg, bqtsc_gain and bqtsc_cell.
//
//   channel   dir   handshake                   payload
//   s_axis    in    s_axis_tvalid/tready        tdata: sample_in
//   m_axis    out   m_axis_tvalid/tready        tdata: sample_out
//   cfg       in    cfg_wr_en (no wait)         cfg_addr, cfg_wdata
//
// A sample passes from accept through the input gain, each biquad cell (none with
// tone bypass), where each cell reuses one multiplier for its five products, the
// output gain and the output register load before the next sample is accepted.
// Reset is synchronous and clears all delays and loads unity coefficients.
// A result waiting in the output register does not stop the next sample from
// being accepted; only the finished second result waits for the first to leave.
module biquad_tone_stack_cascade #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Bits from the lowest: sample_in, then zero fill.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // Bits from the lowest: sample_out, then zero fill.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,
  input  logic                                    cfg_wr_en,
  input  logic [bqtsc_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
  input  logic [3*COEF_BITS-1:0]                  cfg_wdata
);

  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DW  = bqtsc_pkg::DELAY_BITS;
  localparam int NS  = bqtsc_pkg::NUM_STAGES;
  localparam int CF  = COEF_BITS - 3;
  localparam logic [COEF_BITS-1:0] COEF_ONE = {3'b001, {CF{1'b0}}};

  logic [3*COEF_BITS-1:0] ff_reg [NS];
  logic [2*COEF_BITS-1:0] fb_reg [NS];
  logic [2*COEF_BITS-1:0] gains;
  logic                   bypass;

  logic                   busy;
  logic                   pend;
  logic                   in_acc;
  logic                   fin;
  logic                   load;
  logic [SAMPLE_BITS-1:0] out_sample;

  logic                   ig_done;
  logic signed [DW-1:0]   ig_res;
  logic                   og_start;
  logic signed [DW-1:0]   og_din;
  logic                   og_done;
  logic signed [SAMPLE_BITS-1:0] og_res;

  logic                   cell_start [NS];
  logic                   cell_done  [NS];
  logic signed [DW-1:0]   cell_x     [NS];
  logic signed [DW-1:0]   cell_y     [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        ff_reg[k] <= {{(2*COEF_BITS){1'b0}}, COEF_ONE};
        fb_reg[k] <= '0;
      end
      gains  <= {COEF_ONE, COEF_ONE};
      bypass <= 1'b0;
    end else if (cfg_wr_en) begin
      case (bqtsc_pkg::cfg_reg_t'(cfg_addr))
        bqtsc_pkg::REG_BASS_FF:     ff_reg[0] <= cfg_wdata;
        bqtsc_pkg::REG_BASS_FB:     fb_reg[0] <= cfg_wdata[2*COEF_BITS-1:0];
        bqtsc_pkg::REG_MID_FF:      ff_reg[1] <= cfg_wdata;
        bqtsc_pkg::REG_MID_FB:      fb_reg[1] <= cfg_wdata[2*COEF_BITS-1:0];
        bqtsc_pkg::REG_TREBLE_FF:   ff_reg[2] <= cfg_wdata;
        bqtsc_pkg::REG_TREBLE_FB:   fb_reg[2] <= cfg_wdata[2*COEF_BITS-1:0];
        bqtsc_pkg::REG_GAINS:       gains     <= cfg_wdata[2*COEF_BITS-1:0];
        bqtsc_pkg::REG_TONE_BYPASS: bypass    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && !busy;

  bqtsc_gain #(
    .IN_W      (SAMPLE_BITS),
    .OUT_W     (DW),
    .COEF_BITS (COEF_BITS)
  ) u_in_gain (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc),
    .din   ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .gain  ($signed(gains[COEF_BITS-1:0])),
    .done  (ig_done),
    .dout  (ig_res)
  );

  for (genvar k = 0; k < NS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_start[k] = ig_done && !bypass;
      assign cell_x[k]     = ig_res;
    end else begin : g_link
      assign cell_start[k] = cell_done[k-1];
      assign cell_x[k]     = cell_y[k-1];
    end

    bqtsc_cell #(
      .COEF_BITS (COEF_BITS)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .start (cell_start[k]),
      .x     (cell_x[k]),
      .ff    (ff_reg[k]),
      .fb    (fb_reg[k]),
      .done  (cell_done[k]),
      .y     (cell_y[k])
    );
  end

  assign og_start = bypass ? ig_done : cell_done[NS-1];
  assign og_din   = bypass ? ig_res  : cell_y[NS-1];

  bqtsc_gain #(
    .IN_W      (DW),
    .OUT_W     (SAMPLE_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_out_gain (
    .clk   (clk),
    .rst   (rst),
    .start (og_start),
    .din   (og_din),
    .gain  ($signed(gains[2*COEF_BITS-1:COEF_BITS])),
    .done  (og_done),
    .dout  (og_res)
  );

  assign fin  = og_done || pend;
  assign load = fin && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      pend <= fin && !load;
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sample <= og_res;
    end
  end

  assign m_axis_tdata = TDW'(out_sample);

endmodule

@@ src/bqtsc_checker.sv @@
// Port-level checks of the tone stack cascade, bound to its top level.
// Depends on biquad_tone_stack_cascade_macros.svh.
`include "biquad_tone_stack_cascade_macros.svh"

module bqtsc_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // Taking a beat drops s_axis_tready, so samples are taken one at a time.
  `BQTSC_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_beat, !s_axis_tready)
  // m_axis_tvalid never rises in the cycle after a beat is taken.
  `BQTSC_ASSERT_NOW(a_min_latency, clk, rst, $rose(m_axis_tvalid), !$past(in_beat))
  // Reset empties the output register.
  `BQTSC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid)
  // A stalled result stays offered.
  `BQTSC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind biquad_tone_stack_cascade bqtsc_checker u_bqtsc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
